@@ src/scd_pkg.sv @@
// Package for the sound command decoder: shared constants, action codes,
// register indexes and the controller/datapath command and status structs.
package scd_pkg;

	localparam int unsigned IdCount    = 256;
	localparam int unsigned RemapDepth = 16;
	localparam int unsigned HdrSlots   = 32;
	localparam int unsigned CmdW       = 5;

	typedef enum logic [2:0] {
		ACT_COMMAND = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_LD_HDR  = 3'd2,
		ACT_LD_MAP  = 3'd3,
		ACT_LD_FLAG = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_PLAY = 2'd1,
		RES_STOP = 2'd2
	} res_t;

	localparam logic [2:0] REG_IGNORE  = 3'd0;
	localparam logic [2:0] REG_STOP    = 3'd1;
	localparam logic [2:0] REG_HEADER  = 3'd2;
	localparam logic [2:0] REG_TIMEOUT = 3'd3;
	localparam logic [2:0] REG_REPEAT  = 3'd4;
	localparam logic [2:0] REG_RELSTOP = 3'd5;
	localparam logic [2:0] REG_RMCOUNT = 3'd6;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture input request, run decode
		logic scan;     // compare one remap entry and advance
		logic finish;   // check range and repeat, update last id
		logic emit;     // present result
	} ctl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clearing; // flag memory clear after reset still running
		logic scan_end; // remap scan has ended
	} sts_t;

endpackage

@@ src/scd_ctrl.sv @@
// Controller state machine of the sound command decoder.
// Depends on scd_pkg.
module scd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_free,
	input  scd_pkg::sts_t sts,
	output scd_pkg::ctl_t ctl,
	output logic          busy
);
	import scd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t state_q;

	// Drive commands from the state
	always_comb begin
		ctl.load   = in_fire;
		ctl.scan   = (state_q == ST_SCAN) && !sts.scan_end;
		ctl.finish = (state_q == ST_FIN);
		ctl.emit   = (state_q == ST_OUT) && out_free;
		busy       = (state_q != ST_IDLE) || sts.clearing;
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_end) state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ src/scd_dp.sv @@
// Datapath of the sound command decoder: config registers, tables, flag
// memory, armed header and last-id state, remap scan and result register.
// Depends on scd_pkg.
module scd_dp #(
	parameter int unsigned ID_COUNT    = scd_pkg::IdCount,
	parameter int unsigned REMAP_DEPTH = scd_pkg::RemapDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  scd_pkg::ctl_t ctl,
	output scd_pkg::sts_t sts,
	input  logic [2:0]    action,
	input  logic [7:0]    bus_byte,
	input  logic [31:0]   now_ms,
	input  logic [7:0]    slot,
	input  logic [7:0]    value_from,
	input  logic [7:0]    value_to,
	input  logic          flag_voice,
	input  logic          flag_loop,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_addr,
	input  logic [31:0]   cfg_wdata,
	output logic [31:0]   cfg_rdata,
	output logic [1:0]    res_act,
	output logic [7:0]    res_id,
	output logic          res_voice,
	output logic          res_loop
);
	import scd_pkg::*;

	localparam int unsigned RmW = (REMAP_DEPTH > 1) ? $clog2(REMAP_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(REMAP_DEPTH + 1);
	localparam int unsigned IdW = $clog2(ID_COUNT);
	localparam int unsigned ClrW = IdW + 1;
	localparam logic [ClrW-1:0] ClrEnd = ClrW'(ID_COUNT);

	logic [31:0] ignore_q, stop_q, header_q;
	logic [15:0] timeout_q, repeat_q;
	logic        relstop_q;
	logic [4:0]  rmcount_q;

	logic        armed_q;
	logic [7:0]  base_q;
	logic [31:0] armed_time_q;
	logic        last_valid_q;
	logic [7:0]  last_id_q;
	logic [31:0] last_time_q;

	logic [7:0]       hbase_q [HdrSlots];
	logic [7:0]       rsrc_q  [REMAP_DEPTH];
	logic [7:0]       rdst_q  [REMAP_DEPTH];

	// Per-id flags: bit 0 voice, bit 1 loop
	logic [1:0]      flag_mem [ID_COUNT];
	logic [1:0]      flag_rd_q;
	logic [ClrW-1:0] clr_q;
	logic            clearing;

	// Working registers of one request
	logic [8:0]      id_q;
	logic            found_q;
	logic            scan_on_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] lim_q;
	logic [31:0]     now_q;
	logic [1:0]      act_q;

	logic [CmdW-1:0] cmd;
	logic            expired;
	logic [31:0]     hd_age;

	assign cmd     = bus_byte[CmdW-1:0];
	assign hd_age  = now_ms - armed_time_q;
	assign expired = armed_q && (timeout_q != 16'd0) && (hd_age > {16'd0, timeout_q});
	assign clearing = (clr_q < ClrEnd);

	assign sts.clearing = clearing;
	assign sts.scan_end = !scan_on_q || found_q || (idx_q >= lim_q);

	// Register read-back
	always_comb begin
		case (cfg_addr)
			REG_IGNORE:  cfg_rdata = ignore_q;
			REG_STOP:    cfg_rdata = stop_q;
			REG_HEADER:  cfg_rdata = header_q;
			REG_TIMEOUT: cfg_rdata = {16'd0, timeout_q};
			REG_REPEAT:  cfg_rdata = {16'd0, repeat_q};
			REG_RELSTOP: cfg_rdata = {31'd0, relstop_q};
			REG_RMCOUNT: cfg_rdata = {27'd0, rmcount_q};
			default:     cfg_rdata = 32'd0;
		endcase
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q  <= 32'd1;
			stop_q    <= 32'd0;
			header_q  <= 32'd0;
			timeout_q <= 16'd250;
			repeat_q  <= 16'd0;
			relstop_q <= 1'b0;
			rmcount_q <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_IGNORE:  ignore_q  <= cfg_wdata;
				REG_STOP:    stop_q    <= cfg_wdata;
				REG_HEADER:  header_q  <= cfg_wdata;
				REG_TIMEOUT: timeout_q <= cfg_wdata[15:0];
				REG_REPEAT:  repeat_q  <= cfg_wdata[15:0];
				REG_RELSTOP: relstop_q <= cfg_wdata[0];
				REG_RMCOUNT: rmcount_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// Remap table, reset undefined
	always_ff @(posedge clk) begin
		if (ctl.load && action == ACT_LD_MAP && {24'd0, slot} < 32'(REMAP_DEPTH)) begin
			rsrc_q[slot[RmW-1:0]] <= value_from;
			rdst_q[slot[RmW-1:0]] <= value_to;
		end
	end

	// Walk the flag memory once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + 1'b1;
	end

	// Flag memory: clear pass, loads, one registered read at finish
	always_ff @(posedge clk) begin
		if (clearing)
			flag_mem[clr_q[IdW-1:0]] <= 2'b00;
		else if (ctl.load && action == ACT_LD_FLAG && {24'd0, slot} < 32'(ID_COUNT))
			flag_mem[slot[IdW-1:0]] <= {flag_loop, flag_voice};
		if (ctl.finish)
			flag_rd_q <= flag_mem[id_q[IdW-1:0]];
	end

	// Decode on load, scan, then finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			base_q       <= 8'd0;
			armed_time_q <= 32'd0;
			last_valid_q <= 1'b0;
			last_id_q    <= 8'd0;
			last_time_q  <= 32'd0;
			id_q         <= 9'd0;
			now_q        <= 32'd0;
			scan_on_q    <= 1'b0;
			found_q      <= 1'b0;
			idx_q        <= '0;
			lim_q        <= '0;
			act_q        <= RES_NONE;
			for (int i = 0; i < HdrSlots; i++) hbase_q[i] <= 8'd0;
		end else if (ctl.load) begin
			act_q     <= RES_NONE;
			scan_on_q <= 1'b0;
			found_q   <= 1'b0;
			idx_q     <= '0;
			now_q     <= now_ms;
			case (action)
				ACT_COMMAND: begin
					if (expired) begin
						armed_q <= 1'b0;
						base_q  <= 8'd0;
					end
					if (ignore_q[cmd]) begin
						// drop
					end else if (stop_q[cmd]) begin
						armed_q      <= 1'b0;
						base_q       <= 8'd0;
						last_valid_q <= 1'b0;
						act_q        <= RES_STOP;
					end else if (header_q[cmd]) begin
						base_q       <= hbase_q[cmd];
						armed_q      <= 1'b1;
						armed_time_q <= now_ms;
					end else begin
						id_q      <= {4'd0, cmd} + ((armed_q && !expired) ?
						             {1'b0, base_q} : 9'd0);
						armed_q   <= 1'b0;
						base_q    <= 8'd0;
						scan_on_q <= 1'b1;
						lim_q     <= ({27'd0, rmcount_q} > 32'(REMAP_DEPTH)) ?
						             CntW'(REMAP_DEPTH) : CntW'(rmcount_q);
					end
				end
				ACT_RELEASE: begin
					last_valid_q <= 1'b0;
					if (relstop_q) act_q <= RES_STOP;
				end
				ACT_LD_HDR: begin
					if (slot < 8'(HdrSlots)) hbase_q[slot[CmdW-1:0]] <= value_from;
				end
				default: ;
			endcase
		end else if (ctl.scan) begin
			// compare one entry per cycle
			if ({1'b0, rsrc_q[idx_q[RmW-1:0]]} == id_q) begin
				id_q    <= {1'b0, rdst_q[idx_q[RmW-1:0]]};
				found_q <= 1'b1;
			end
			idx_q <= idx_q + 1'b1;
		end else if (ctl.finish && scan_on_q) begin
			scan_on_q <= 1'b0;
			if (id_q < 9'(ID_COUNT)) begin
				if (!(repeat_q != 16'd0 && last_valid_q && id_q[7:0] == last_id_q &&
				      (now_q - last_time_q) < {16'd0, repeat_q})) begin
					last_valid_q <= 1'b1;
					last_id_q    <= id_q[7:0];
					last_time_q  <= now_q;
					act_q        <= RES_PLAY;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			res_act   <= act_q;
			res_id    <= (act_q == RES_PLAY) ? id_q[7:0] : 8'd0;
			res_voice <= (act_q == RES_PLAY) && flag_rd_q[0];
			res_loop  <= (act_q == RES_PLAY) && flag_rd_q[1];
		end
	end
endmodule

@@ src/sound_command_decoder_top.sv @@
// Top level of the sound command decoder: stream ports, APB register port,
// controller and datapath. Depends on scd_pkg, scd_ctrl, scd_dp.
//
// Each request yields exactly one result. The result register loads after the
// request has passed the scan state, in which remap entries are compared in
// order (at most min(remap_count, REMAP_DEPTH), fewer on an early match), and
// the finish state, and only once the output is free. A new request is taken
// only after the result register has loaded, so the block never takes a new
// request before it is through with the last. The result register lets the next
// request enter while a result waits to be taken. After reset the per-id flag
// memory is cleared, one entry per cycle, and s_tready stays low until then.
module sound_command_decoder_top #(
	parameter int unsigned ID_COUNT    = scd_pkg::IdCount,
	parameter int unsigned REMAP_DEPTH = scd_pkg::RemapDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] action, [10:3] bus_byte, [42:11] now_ms, [50:43] slot,
	// [58:51] value_from, [66:59] value_to, [67] flag_voice, [68] flag_loop
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] act, [9:2] sample_id, [10] is_voice, [11] is_loop
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import scd_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy, in_fire, out_free, cfg_we;
	logic       out_valid_q;
	logic [1:0] r_act;
	logic [7:0] r_id;
	logic       r_voice, r_loop;

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, r_loop, r_voice, r_id, r_act};

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (ctl.emit) out_valid_q <= 1'b1;
		else if (m_tready) out_valid_q <= 1'b0;
	end

	scd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_free(out_free),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	scd_dp #(.ID_COUNT(ID_COUNT), .REMAP_DEPTH(REMAP_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.action(s_tdata[2:0]), .bus_byte(s_tdata[10:3]), .now_ms(s_tdata[42:11]),
		.slot(s_tdata[50:43]), .value_from(s_tdata[58:51]),
		.value_to(s_tdata[66:59]), .flag_voice(s_tdata[67]),
		.flag_loop(s_tdata[68]),
		.cfg_we(cfg_we), .cfg_addr(paddr[4:2]), .cfg_wdata(pwdata),
		.cfg_rdata(prdata),
		.res_act(r_act), .res_id(r_id), .res_voice(r_voice), .res_loop(r_loop)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire) else $error("request taken while busy");
	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> m_tvalid) else $error("result lost");
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] != RES_PLAY) |-> m_tdata[11:2] == 10'd0)
		else $error("non-play result carries data");
endmodule
